// ===== design/tppl_pkg.sv =====
`timescale 1ns / 1ps

package tppl_pkg;

    localparam int TEMP_W = 16;
    localparam int DRIVE_W = 16;
    localparam int STATUS_W = 2;
    localparam int GAIN_W = 24;
    localparam int COEF_W = 16;
    localparam int REG_ADDR_W = 5;
    localparam int REG_IDX_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W = 2 * MUL_B_W;
    localparam int SUM_W = 48;

    localparam int PLANT_SHIFT = 23;
    localparam int LOSS_SHIFT = 7;
    localparam int PID_SHIFT = 9;
    localparam logic signed [SUM_W-1:0] PLANT_ROUND = SUM_W'(64'sd4194304);
    localparam logic signed [SUM_W-1:0] PID_ROUND = SUM_W'(64'sd256);

    localparam int ITERM_W = 45;
    localparam logic [ITERM_W-1:0] ITERM_LIMIT = {1'b1, {(ITERM_W - 1){1'b0}}};

    localparam int TEMP_MAX = 32767;
    localparam int TEMP_MIN = -32768;
    localparam logic [DRIVE_W-1:0] DRIVE_FULL = 16'h8000;

    localparam logic [STATUS_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] CLAMP_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] CLAMP_ZERO = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMBIENT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROP = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTEG = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DERIV = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HEAT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LOSS = 3'd6;

    localparam logic [TEMP_W-1:0] TARGET_RESET = 16'd6400;
    localparam logic [TEMP_W-1:0] AMBIENT_RESET = 16'd5120;
    localparam logic [GAIN_W-1:0] PROP_RESET = 24'd163840;
    localparam logic [GAIN_W-1:0] INTEG_RESET = 24'd655;
    localparam logic [GAIN_W-1:0] DERIV_RESET = 24'd32768;
    localparam logic [COEF_W-1:0] HEAT_RESET = 16'd13107;
    localparam logic [COEF_W-1:0] LOSS_RESET = 16'd328;
    localparam logic [TEMP_W-1:0] PLANT_RESET = 16'd5120;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAT,
        ST_LOSS,
        ST_LOSS_ACC,
        ST_TEMP,
        ST_ERR,
        ST_PROP,
        ST_DERIV,
        ST_INTEG,
        ST_INTEG_ACC,
        ST_INTEG_SAT,
        ST_INTEG_ADD,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MUL_HEAT,
        MUL_LOSS,
        MUL_PROP,
        MUL_DERIV,
        MUL_INTEG
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_HEAT,
        ACC_SUB_LOSS,
        ACC_LOAD_PROP,
        ACC_ADD_PROD,
        ACC_ADD_INTEG
    } acc_op_t;

    typedef enum logic [1:0] {
        IACC_HOLD,
        IACC_CLEAR,
        IACC_SHIFT_ADD
    } iacc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        iacc_op_t iacc_op;
        logic     temp_en;
        logic     err_en;
        logic     sum_en;
        logic     mag_shift;
        logic     isat_en;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [TEMP_W-1:0] setpoint;
        logic [TEMP_W-1:0] ambient_temp;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [COEF_W-1:0] heat_gain;
        logic [COEF_W-1:0] loss_gain;
    } cfg_t;

endpackage

// ===== design/tppl_tick_if.sv =====
`timescale 1ns / 1ps

interface tppl_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// ===== design/tppl_result_if.sv =====
`timescale 1ns / 1ps

interface tppl_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [tppl_pkg::TEMP_W-1:0]  temperature;
    logic [tppl_pkg::DRIVE_W-1:0]        drive;
    logic signed [tppl_pkg::TEMP_W-1:0]  error;
    logic [tppl_pkg::STATUS_W-1:0]       clamp_status;

    modport source (output valid, output temperature, output drive, output error,
                    output clamp_status, input ready);
    modport sink (input valid, input temperature, input drive, input error,
                  input clamp_status, output ready);
endinterface

// ===== design/tppl_regs.sv =====
`timescale 1ns / 1ps

module tppl_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tppl_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [tppl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tppl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output tppl_pkg::cfg_t                    cfg
);
    import tppl_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[REG_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint <= TARGET_RESET;
            cfg_reg.ambient_temp <= AMBIENT_RESET;
            cfg_reg.prop_gain <= PROP_RESET;
            cfg_reg.integ_gain <= INTEG_RESET;
            cfg_reg.deriv_gain <= DERIV_RESET;
            cfg_reg.heat_gain <= HEAT_RESET;
            cfg_reg.loss_gain <= LOSS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TARGET:  cfg_reg.setpoint <= pwdata[TEMP_W-1:0];
                REG_AMBIENT: cfg_reg.ambient_temp <= pwdata[TEMP_W-1:0];
                REG_PROP:    cfg_reg.prop_gain <= pwdata[GAIN_W-1:0];
                REG_INTEG:   cfg_reg.integ_gain <= pwdata[GAIN_W-1:0];
                REG_DERIV:   cfg_reg.deriv_gain <= pwdata[GAIN_W-1:0];
                REG_HEAT:    cfg_reg.heat_gain <= pwdata[COEF_W-1:0];
                REG_LOSS:    cfg_reg.loss_gain <= pwdata[COEF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TARGET:  prdata = APB_DATA_W'(cfg_reg.setpoint);
            REG_AMBIENT: prdata = APB_DATA_W'(cfg_reg.ambient_temp);
            REG_PROP:    prdata = APB_DATA_W'(cfg_reg.prop_gain);
            REG_INTEG:   prdata = APB_DATA_W'(cfg_reg.integ_gain);
            REG_DERIV:   prdata = APB_DATA_W'(cfg_reg.deriv_gain);
            REG_HEAT:    prdata = APB_DATA_W'(cfg_reg.heat_gain);
            REG_LOSS:    prdata = APB_DATA_W'(cfg_reg.loss_gain);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== design/tppl_ctrl.sv =====
`timescale 1ns / 1ps

module tppl_ctrl #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    tppl_tick_if.sink           tick_stream,
    input  tppl_pkg::dp_stat_t  stat,
    output tppl_pkg::dp_cmd_t   cmd
);
    import tppl_pkg::*;

    localparam int NCHUNK = (ACC_WIDTH + GAIN_W - 1) / GAIN_W;
    localparam int CNT_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCHUNK - 1);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        cmd.mul_sel = MUL_HEAT;
        cmd.acc_op = ACC_HOLD;
        cmd.iacc_op = IACC_HOLD;
        tick_stream.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick_stream.ready = 1'b1;
                if (tick_stream.valid && tick_stream.tick)
                begin
                    state_next = ST_HEAT;
                end
            end
            ST_HEAT:
            begin
                cmd.mul_sel = MUL_HEAT;
                state_next = ST_LOSS;
            end
            ST_LOSS:
            begin
                cmd.mul_sel = MUL_LOSS;
                cmd.acc_op = ACC_LOAD_HEAT;
                state_next = ST_LOSS_ACC;
            end
            ST_LOSS_ACC:
            begin
                cmd.acc_op = ACC_SUB_LOSS;
                state_next = ST_TEMP;
            end
            ST_TEMP:
            begin
                cmd.temp_en = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                cmd.mul_sel = MUL_PROP;
                cmd.sum_en = 1'b1;
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                cmd.mul_sel = MUL_DERIV;
                cmd.acc_op = ACC_LOAD_PROP;
                cmd.iacc_op = IACC_CLEAR;
                cnt_next = '0;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.mul_sel = MUL_INTEG;
                cmd.mag_shift = 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.acc_op = ACC_ADD_PROD;
                end
                else
                begin
                    cmd.iacc_op = IACC_SHIFT_ADD;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_INTEG_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_INTEG_ACC:
            begin
                cmd.iacc_op = IACC_SHIFT_ADD;
                state_next = ST_INTEG_SAT;
            end
            ST_INTEG_SAT:
            begin
                cmd.isat_en = 1'b1;
                state_next = ST_INTEG_ADD;
            end
            ST_INTEG_ADD:
            begin
                cmd.acc_op = ACC_ADD_INTEG;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tppl_dpath.sv =====
`timescale 1ns / 1ps

module tppl_dpath #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tppl_pkg::cfg_t      cfg,
    input  tppl_pkg::dp_cmd_t   cmd,
    output tppl_pkg::dp_stat_t  stat,
    tppl_result_if.source       result_stream
);
    import tppl_pkg::*;

    localparam int NCHUNK = (ACC_WIDTH + GAIN_W - 1) / GAIN_W;
    localparam int MAG_W = NCHUNK * GAIN_W;
    localparam int IACC_W = MAG_W + GAIN_W;
    localparam int STEP_W = SUM_W - PLANT_SHIFT;
    localparam int TSUM_W = STEP_W + 1;
    localparam int U_W = SUM_W - PID_SHIFT;

    // Loop state.
    logic signed [TEMP_W-1:0]    temp_reg;
    logic [DRIVE_W-1:0]          drive_reg;
    logic signed [ACC_WIDTH-1:0] error_sum_reg;
    logic signed [TEMP_W-1:0]    prev_err_reg;

    // Working registers for one tick.
    logic signed [TEMP_W-1:0]    err_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [SUM_W-1:0]     acc_reg;
    logic signed [SUM_W-1:0]     acc_next;
    logic [MAG_W-1:0]            mag_sh_reg;
    logic [IACC_W-1:0]           iacc_reg;
    logic [ITERM_W-1:0]          isat_reg;

    logic                        out_valid_reg;
    logic signed [TEMP_W-1:0]    out_temp_reg;
    logic [DRIVE_W-1:0]          out_drive_reg;
    logic signed [TEMP_W-1:0]    out_err_reg;
    logic [STATUS_W-1:0]         out_status_reg;

    logic [GAIN_W-1:0]           mul_a;
    logic signed [MUL_B_W-1:0]   mul_a_s;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [TEMP_W:0]      dtemp;
    logic signed [TEMP_W:0]      diff;
    logic signed [SUM_W-1:0]     prod_s;
    logic signed [SUM_W-1:0]     isat_s;
    logic signed [STEP_W-1:0]    step;
    logic signed [TSUM_W-1:0]    temp_sum;
    logic signed [TEMP_W-1:0]    temp_new;
    logic signed [TEMP_W:0]      err_wide;
    logic signed [TEMP_W-1:0]    err_new;
    logic signed [ACC_WIDTH:0]   esum_wide;
    logic signed [ACC_WIDTH-1:0] esum_new;
    logic                        es_neg;
    logic [ACC_WIDTH-1:0]        es_abs;
    logic [IACC_W-1:0]           iacc_next;
    logic [ITERM_W-1:0]          isat_new;
    logic signed [U_W-1:0]       u_val;
    logic [DRIVE_W-1:0]          drive_new;
    logic [STATUS_W-1:0]         status_new;

    assign dtemp = TEMP_W'(temp_reg) - $signed({cfg.ambient_temp[TEMP_W-1], cfg.ambient_temp});
    assign diff = (TEMP_W + 1)'(err_reg) - (TEMP_W + 1)'(prev_err_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_HEAT:
            begin
                mul_a = GAIN_W'(cfg.heat_gain);
                mul_b = MUL_B_W'($signed({1'b0, drive_reg}));
            end
            MUL_LOSS:
            begin
                mul_a = GAIN_W'(cfg.loss_gain);
                mul_b = MUL_B_W'(dtemp);
            end
            MUL_PROP:
            begin
                mul_a = cfg.prop_gain;
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_DERIV:
            begin
                mul_a = cfg.deriv_gain;
                mul_b = MUL_B_W'(diff);
            end
            MUL_INTEG:
            begin
                mul_a = cfg.integ_gain;
                mul_b = $signed({1'b0, mag_sh_reg[MAG_W-1 -: GAIN_W]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_a_s = $signed({1'b0, mul_a});
    assign prod_next = mul_a_s * mul_b;
    assign prod_s = prod_reg[SUM_W-1:0];
    assign isat_s = $signed(SUM_W'(isat_reg));

    assign es_neg = error_sum_reg[ACC_WIDTH-1];

    always_comb
    begin
        case (cmd.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_LOAD_HEAT: acc_next = prod_s + PLANT_ROUND;
            ACC_SUB_LOSS:  acc_next = acc_reg - (prod_s <<< LOSS_SHIFT);
            ACC_LOAD_PROP: acc_next = prod_s + PID_ROUND;
            ACC_ADD_PROD:  acc_next = acc_reg + prod_s;
            ACC_ADD_INTEG: acc_next = es_neg ? (acc_reg - isat_s) : (acc_reg + isat_s);
            default:       acc_next = acc_reg;
        endcase
    end

    // Plant update: floor shift of the rounded change, then saturate.
    assign step = $signed(acc_reg[SUM_W-1:PLANT_SHIFT]);
    assign temp_sum = TSUM_W'(temp_reg) + TSUM_W'(step);

    always_comb
    begin
        if (temp_sum > TEMP_MAX)
        begin
            temp_new = TEMP_W'(TEMP_MAX);
        end
        else if (temp_sum < TEMP_MIN)
        begin
            temp_new = TEMP_W'(TEMP_MIN);
        end
        else
        begin
            temp_new = temp_sum[TEMP_W-1:0];
        end
    end

    assign err_wide = $signed({cfg.setpoint[TEMP_W-1], cfg.setpoint})
                      - (TEMP_W + 1)'(temp_reg);

    always_comb
    begin
        if (err_wide[TEMP_W] != err_wide[TEMP_W-1])
        begin
            err_new = {err_wide[TEMP_W], {(TEMP_W - 1){~err_wide[TEMP_W]}}};
        end
        else
        begin
            err_new = err_wide[TEMP_W-1:0];
        end
    end

    assign esum_wide = (ACC_WIDTH + 1)'(error_sum_reg) + (ACC_WIDTH + 1)'(err_reg);

    always_comb
    begin
        if (esum_wide[ACC_WIDTH] != esum_wide[ACC_WIDTH-1])
        begin
            esum_new = {esum_wide[ACC_WIDTH], {(ACC_WIDTH - 1){~esum_wide[ACC_WIDTH]}}};
        end
        else
        begin
            esum_new = esum_wide[ACC_WIDTH-1:0];
        end
    end

    assign es_abs = es_neg ? (~error_sum_reg + 1'b1) : error_sum_reg;

    always_comb
    begin
        case (cmd.iacc_op)
            IACC_HOLD:      iacc_next = iacc_reg;
            IACC_CLEAR:     iacc_next = '0;
            IACC_SHIFT_ADD: iacc_next = (iacc_reg << GAIN_W)
                                        + IACC_W'(prod_reg[2*GAIN_W-1:0]);
            default:        iacc_next = iacc_reg;
        endcase
    end

    assign isat_new = (iacc_reg > IACC_W'(ITERM_LIMIT)) ? ITERM_LIMIT
                                                        : iacc_reg[ITERM_W-1:0];

    assign u_val = $signed(acc_reg[SUM_W-1:PID_SHIFT]);

    always_comb
    begin
        if (u_val > U_W'($signed({1'b0, DRIVE_FULL})))
        begin
            drive_new = DRIVE_FULL;
            status_new = CLAMP_FULL;
        end
        else if (u_val < 0)
        begin
            drive_new = '0;
            status_new = CLAMP_ZERO;
        end
        else
        begin
            drive_new = u_val[DRIVE_W-1:0];
            status_new = CLAMP_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg <= PLANT_RESET;
            drive_reg <= '0;
            error_sum_reg <= '0;
            prev_err_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.temp_en)
            begin
                temp_reg <= temp_new;
            end
            if (cmd.sum_en)
            begin
                error_sum_reg <= esum_new;
            end
            if (cmd.finish)
            begin
                drive_reg <= drive_new;
                prev_err_reg <= err_reg;
                out_valid_reg <= 1'b1;
            end
            else if (result_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        iacc_reg <= iacc_next;
        if (cmd.err_en)
        begin
            err_reg <= err_new;
        end
        if (cmd.iacc_op == IACC_CLEAR)
        begin
            mag_sh_reg <= MAG_W'(es_abs);
        end
        else if (cmd.mag_shift)
        begin
            mag_sh_reg <= mag_sh_reg << GAIN_W;
        end
        if (cmd.isat_en)
        begin
            isat_reg <= isat_new;
        end
        if (cmd.finish)
        begin
            out_temp_reg <= temp_reg;
            out_drive_reg <= drive_new;
            out_err_reg <= err_reg;
            out_status_reg <= status_new;
        end
    end

    assign stat.out_busy = out_valid_reg && !result_stream.ready;

    assign result_stream.valid = out_valid_reg;
    assign result_stream.temperature = out_temp_reg;
    assign result_stream.drive = out_drive_reg;
    assign result_stream.error = out_err_reg;
    assign result_stream.clamp_status = out_status_reg;

endmodule

// ===== design/thermal_plant_pid_loop.sv =====
`timescale 1ns / 1ps

// Thermal plant model closed by a PID heater loop. Each tick word with the tick bit set
// advances the Q8.8 plant one period and runs one PID step, and yields one result word
// with the new temperature, drive, error and clamp status; a tick word with the bit clear
// is taken and ignored. A new tick word is taken only once the previous tick has finished,
// because every product goes through one shared 25x25 multiplier, one product per cycle,
// with the integral term built from 24-bit slices of the ACC_WIDTH-bit integrator. The
// result word is registered when its tick finishes. The result sits in an output
// register, so the block waits only when a previous result word is still unread at the
// end of the next tick. Registers are written through the APB port at byte address
// 4*index and should change only while no tick is in flight.
module thermal_plant_pid_loop #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tppl_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [tppl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tppl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    tppl_tick_if.sink                         tick_stream,
    tppl_result_if.source                     result_stream
);
    import tppl_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    tppl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tppl_ctrl #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_stream (tick_stream),
        .stat        (stat),
        .cmd         (cmd)
    );

    tppl_dpath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .result_stream (result_stream)
    );

`ifndef ASSERT_OFF
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_stream.valid) |-> $past(cmd.finish))
        else $error("Result word appeared without a finished tick.");

    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_stream.valid && tick_stream.ready && tick_stream.tick)
        |=> (!tick_stream.ready && !cmd.finish))
        else $error("Tick word taken while a tick is still being worked.");

    a_clamp_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_stream.valid && result_stream.clamp_status == CLAMP_FULL)
        |-> (result_stream.drive == DRIVE_FULL))
        else $error("Full clamp reported with drive below full power.");

    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_stream.valid && result_stream.clamp_status == CLAMP_ZERO)
        |-> (result_stream.drive == '0))
        else $error("Zero clamp reported with nonzero drive.");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_stream.valid |-> (result_stream.drive <= DRIVE_FULL
                                 && (result_stream.clamp_status == CLAMP_NONE
                                     || result_stream.clamp_status == CLAMP_FULL
                                     || result_stream.clamp_status == CLAMP_ZERO)))
        else $error("Drive or clamp status out of range.");
`endif

endmodule
